@@ hw/rtl/crc_pkg.sv @@
// ----------------------------------------------------------------------------
// crc_pkg
// Shared types and constants for the candle regime classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package crc_pkg;

  localparam int PRICE_W         = 32;
  localparam int SCORE_W         = 16;
  localparam int THR_W           = 15;
  localparam int POS_W           = 16;
  localparam int REGIME_W        = 4;
  localparam int WINDOW_DEF      = 20;
  localparam int MIN_CANDLES_DEF = 5;

  localparam logic [THR_W-1:0] THR_RESET = 15'd1229;
  localparam logic [POS_W-1:0] POS_MID   = 16'h8000;
  localparam logic [POS_W-1:0] POS_MAX   = 16'hFFFF;
  localparam logic [POS_W-1:0] POS_ZERO  = 16'h0000;

  typedef enum logic [REGIME_W-1:0] {
    REG_UNCERTAIN  = 4'd0,
    REG_MANIP      = 4'd1,
    REG_BREAK_UP   = 4'd2,
    REG_BREAK_DOWN = 4'd3,
    REG_STRONG_UP  = 4'd4,
    REG_STRONG_DN  = 4'd5,
    REG_CORR_UP    = 4'd6,
    REG_CORR_DN    = 4'd7,
    REG_RANGE      = 4'd8
  } regime_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_C,
    ST_EVAL,
    ST_DIVIDE,
    ST_OUTPUT
  } seq_state_t;

  typedef struct packed {
    logic [PRICE_W-1:0] a;
    logic [PRICE_W-1:0] b;
  } mul_op_t;

endpackage

`default_nettype wire

@@ hw/rtl/crc_candle_if.sv @@
// ----------------------------------------------------------------------------
// crc_candle_if
// Candle input channel: valid/ready with the candle fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface crc_candle_if
  import crc_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [PRICE_W-1:0]        open_price;
  logic [PRICE_W-1:0]        high_price;
  logic [PRICE_W-1:0]        low_price;
  logic [PRICE_W-1:0]        close_price;
  logic [PRICE_W-1:0]        atr_value;
  logic [PRICE_W-1:0]        mean_atr;
  logic signed [SCORE_W-1:0] hourly_score;
  logic signed [SCORE_W-1:0] four_hour_score;

  modport source (
    output valid, open_price, high_price, low_price, close_price,
           atr_value, mean_atr, hourly_score, four_hour_score,
    input  ready
  );
  modport sink (
    input  valid, open_price, high_price, low_price, close_price,
           atr_value, mean_atr, hourly_score, four_hour_score,
    output ready
  );
endinterface

`default_nettype wire

@@ hw/rtl/crc_result_if.sv @@
// ----------------------------------------------------------------------------
// crc_result_if
// Result channel: valid/ready with regime code and channel position.
// ----------------------------------------------------------------------------
`default_nettype none

interface crc_result_if
  import crc_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [REGIME_W-1:0] regime;
  logic [POS_W-1:0]    channel_position;

  modport source (output valid, regime, channel_position, input ready);
  modport sink   (input  valid, regime, channel_position, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/crc_mul.sv @@
// ----------------------------------------------------------------------------
// crc_mul
// Shared 32x32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module crc_mul
  import crc_pkg::*;
(
  input  wire logic                   clk,
  input  wire mul_op_t                op,
  output logic      [2*PRICE_W-1:0]   prod
);

  always_ff @(posedge clk) begin
    prod <= op.a * op.b;
  end

endmodule

`default_nettype wire

@@ hw/rtl/crc_div.sv @@
// ----------------------------------------------------------------------------
// crc_div
// Restoring divider giving a 16-bit fraction of num/den, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module crc_div
  import crc_pkg::*;
#(
  parameter int DEN_W = 40
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DEN_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [POS_W-1:0]      quot
);

  localparam int CNT_W = $clog2(POS_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   rem;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   rem_shift;
  logic             take;

  // num is below den, so the doubled remainder fits one extra bit
  assign rem_shift = {rem[DEN_W-1:0], 1'b0};
  assign take      = rem_shift >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(POS_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= {1'b0, num};
      den_r <= den;
    end else if (busy) begin
      rem  <= take ? rem_shift - {1'b0, den_r} : rem_shift;
      quot <= {quot[POS_W-2:0], take};
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/candle_regime_classifier.sv @@
// ----------------------------------------------------------------------------
// candle_regime_classifier
// Regime classification and MA channel position for one candle a transaction.
// ----------------------------------------------------------------------------
// One candle is taken at a time; the block drops ready from acceptance until
// its result transaction completes. The divider is skipped when the channel
// position is trivial (window not yet full, zero ATR, or position clamped),
// and the result may wait for ready. Each candle makes two passes through
// the shared 32x32 multiplier for the breakout cross-products; a 16-step
// restoring divider gives the Q0.16 channel position. The close window lives
// in a small memory read at one address a cycle.
`default_nettype none

module candle_regime_classifier
  import crc_pkg::*;
#(
  parameter int WINDOW      = WINDOW_DEF,
  parameter int MIN_CANDLES = MIN_CANDLES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  crc_candle_if.sink              in_ch,
  crc_result_if.source            out_ch,
  input  wire logic               cfg_we,
  input  wire logic [THR_W-1:0]   cfg_wdata
);

  localparam int PTR_W   = $clog2(WINDOW);
  localparam int CNT_W   = $clog2(WINDOW + 1);
  localparam int SUM_W   = PRICE_W + $clog2(WINDOW + 1);
  localparam int DEN_W   = PRICE_W + $clog2(4 * WINDOW + 1);
  localparam int NUM_W   = DEN_W + 1;
  localparam int MIN_EFF = (MIN_CANDLES < WINDOW) ? MIN_CANDLES : WINDOW;
  localparam int PROD_W  = 2 * PRICE_W;

  seq_state_t state, state_next;

  logic [PRICE_W-1:0]        open_r, high_r, low_r, close_r, atr_r, avg_r;
  logic signed [SCORE_W-1:0] s1_r, s4_r;
  logic [THR_W-1:0]          thr;
  logic [PRICE_W-1:0]        window_mem [WINDOW];
  logic [PRICE_W-1:0]        rd_data;
  logic [SUM_W-1:0]          close_sum;
  logic [PTR_W-1:0]          ptr, ptr_inc;
  logic [CNT_W-1:0]          count;
  logic [PRICE_W-1:0]        prev1, prev2;
  logic [PROD_W-1:0]         p1, mul_p;
  regime_t                   regime_r, regime_c;
  logic [POS_W-1:0]          pos_r;
  mul_op_t                   mul_op;
  logic                      div_start, div_done;
  logic [POS_W-1:0]          div_q;
  logic                      chan_trivial;

  assign ptr_inc = (ptr == PTR_W'(WINDOW - 1)) ? '0 : ptr + 1'b1;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE:   if (in_ch.valid) state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_MUL_A;
      ST_MUL_A:  state_next = ST_MUL_B;
      ST_MUL_B:  state_next = ST_MUL_C;
      ST_MUL_C:  state_next = ST_EVAL;
      ST_EVAL: begin
        if (chan_trivial) begin
          state_next = ST_OUTPUT;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: if (div_done) state_next = ST_OUTPUT;
      ST_OUTPUT: if (out_ch.ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  assign in_ch.ready             = (state == ST_IDLE);
  assign out_ch.valid            = (state == ST_OUTPUT);
  assign out_ch.regime           = regime_r;
  assign out_ch.channel_position = pos_r;

  // shared multiplier: dr*c2 then dp*c1
  logic [PRICE_W-1:0] dr, dp;
  assign dr = (close_r >= prev1) ? close_r - prev1 : prev1 - close_r;
  assign dp = (prev1 >= prev2) ? prev1 - prev2 : prev2 - prev1;

  // dp*c1 is held on the multiplier so it is still there at evaluation
  always_comb begin
    if (state == ST_MUL_B || state == ST_MUL_C) mul_op = '{a: dp, b: prev1};
    else                                        mul_op = '{a: dr, b: prev2};
  end

  crc_mul u_mul (.clk(clk), .op(mul_op), .prod(mul_p));

  // manipulation
  logic [PRICE_W-1:0] top, bot;
  logic signed [37:0] rng_m, up_m, lo_m;
  logic               wick_ok, move_ok, manip;
  assign top   = (open_r > close_r) ? open_r : close_r;
  assign bot   = (open_r < close_r) ? open_r : close_r;
  assign rng_m = $signed({6'b0, high_r}) - $signed({6'b0, low_r});
  assign up_m  = $signed({6'b0, high_r}) - $signed({6'b0, top});
  assign lo_m  = $signed({6'b0, bot}) - $signed({6'b0, low_r});
  assign wick_ok = (up_m * 38'sd10 > rng_m * 38'sd7) || (lo_m * 38'sd10 > rng_m * 38'sd7);
  assign move_ok = ({8'b0, dr} * 40'd100) > ({8'b0, prev1} * 40'd3);
  assign manip   = (high_r > low_r) && wick_ok && (prev1 != '0) && move_ok;

  // breakout, with the second product straight from the multiplier
  logic [PROD_W+1:0] lhs_b, rhs_b;
  logic              brk, up_move, dn_move;
  assign lhs_b = {1'b0, p1, 1'b0};
  assign rhs_b = {2'b0, mul_p} + {1'b0, mul_p, 1'b0};
  assign brk   = !(({2'b0, atr_r} * 34'd2) < ({2'b0, avg_r} * 34'd3))
              && (prev1 != '0) && (prev2 != '0) && (lhs_b > rhs_b)
              && (({6'b0, dr} * 38'd50) > {6'b0, prev1});
  assign up_move = (close_r > prev1) && (({8'b0, dr} * 40'd100) > {8'b0, prev1});
  assign dn_move = (close_r < prev1) && (({8'b0, dr} * 40'd100) > {8'b0, prev1});

  // timeframe scores
  logic signed [SCORE_W:0] thr_s, s1_x, s4_x;
  logic                    h1u, h1d, h4u, h4d;
  assign thr_s = $signed({2'b0, thr});
  assign s1_x  = {s1_r[SCORE_W-1], s1_r};
  assign s4_x  = {s4_r[SCORE_W-1], s4_r};
  assign h1u   = s1_x > thr_s;
  assign h1d   = s1_x < -thr_s;
  assign h4u   = s4_x > thr_s;
  assign h4d   = s4_x < -thr_s;

  // range test against the oldest close
  logic               full;
  logic [SUM_W-1:0]   wo, dsum;
  logic               ranging;
  assign full    = (count == CNT_W'(WINDOW));
  assign wo      = SUM_W'(rd_data) * SUM_W'(WINDOW);
  assign dsum    = (close_sum >= wo) ? close_sum - wo : wo - close_sum;
  assign ranging = full && !(({3'b0, atr_r} * 35'd5) > ({3'b0, avg_r} * 35'd4))
                && (rd_data != '0) && (({7'b0, dsum} * (SUM_W+7)'(100)) < {7'b0, wo});

  always_comb begin
    regime_c = REG_UNCERTAIN;
    if (count >= CNT_W'(MIN_EFF)) begin
      priority if (manip)              regime_c = REG_MANIP;
      else if (brk && up_move)         regime_c = REG_BREAK_UP;
      else if (brk && dn_move)         regime_c = REG_BREAK_DOWN;
      else if (h4u && h1u)             regime_c = REG_STRONG_UP;
      else if (h4d && h1d)             regime_c = REG_STRONG_DN;
      else if (h4u && h1d)             regime_c = REG_CORR_UP;
      else if (h4d && h1u)             regime_c = REG_CORR_DN;
      else if (ranging)                regime_c = REG_RANGE;
      else if (h4u)                    regime_c = REG_STRONG_UP;
      else if (h4d)                    regime_c = REG_STRONG_DN;
      else                             regime_c = REG_UNCERTAIN;
    end
  end

  // channel position
  logic [NUM_W-1:0] num;
  logic [DEN_W-1:0] den;
  logic             num_le0, num_ge_den;
  logic [POS_W-1:0] pos_trivial;
  assign num = NUM_W'(close_r) * NUM_W'(WINDOW) - NUM_W'(close_sum)
             + NUM_W'(atr_r) * NUM_W'(2 * WINDOW);
  assign den = DEN_W'(atr_r) * DEN_W'(4 * WINDOW);
  assign num_le0    = num[NUM_W-1] || (num == '0);
  assign num_ge_den = num >= {1'b0, den};
  assign chan_trivial = !full || (atr_r == '0) || num_le0 || num_ge_den;

  always_comb begin
    priority if (!full || atr_r == '0) pos_trivial = POS_MID;
    else if (num_le0)                  pos_trivial = POS_ZERO;
    else                               pos_trivial = POS_MAX;
  end

  crc_div #(.DEN_W(DEN_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num[DEN_W-1:0]),
    .den   (den),
    .done  (div_done),
    .quot  (div_q)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      thr       <= THR_RESET;
      close_sum <= '0;
      ptr       <= '0;
      count     <= '0;
      prev1     <= '0;
      prev2     <= '0;
    end else begin
      if (cfg_we) thr <= cfg_wdata;
      if (state == ST_UPDATE) begin
        if (full) close_sum <= close_sum - SUM_W'(rd_data) + SUM_W'(close_r);
        else begin
          close_sum <= close_sum + SUM_W'(close_r);
          count     <= count + 1'b1;
        end
        ptr <= ptr_inc;
      end
      if (state == ST_EVAL) begin
        prev2 <= prev1;
        prev1 <= close_r;
      end
    end
  end

  // window memory and payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_ch.valid) begin
      rd_data <= window_mem[ptr];
      open_r  <= in_ch.open_price;
      high_r  <= in_ch.high_price;
      low_r   <= in_ch.low_price;
      close_r <= in_ch.close_price;
      atr_r   <= in_ch.atr_value;
      avg_r   <= in_ch.mean_atr;
      s1_r    <= in_ch.hourly_score;
      s4_r    <= in_ch.four_hour_score;
    end
    if (state == ST_UPDATE) begin
      window_mem[ptr] <= close_r;
      rd_data         <= window_mem[ptr_inc];
    end
    if (state == ST_MUL_B) p1 <= mul_p;
    if (state == ST_EVAL) begin
      regime_r <= regime_c;
      pos_r    <= pos_trivial;
    end
    if (state == ST_DIVIDE && div_done) pos_r <= div_q;
  end

endmodule

`default_nettype wire
